// ----- sv/xcwf_pkg.sv -----
// ----------------------------------------------------------------------------
// xcwf_pkg
// Types and constants shared by the word framer modules: channel payloads,
// the command passed from front to back, and the receive phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package xcwf_pkg;

  localparam logic [7:0] SyncByteReset = 8'hA5;

  localparam logic KindRxByte = 1'b0;
  localparam logic KindTxWord = 1'b1;

  localparam logic ResultRxWord = 1'b0;
  localparam logic ResultTxByte = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rx_byte;
    logic [15:0] tx_word;
  } xcwf_in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] rx_word;
    logic [7:0]  tx_byte;
    logic        last;
  } xcwf_out_item_t;

  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhHigh  = 2'd1,
    PhLow   = 2'd2,
    PhCheck = 2'd3
  } xcwf_phase_e;

  typedef enum logic {
    CmdDeliver = 1'b0,
    CmdSend    = 1'b1
  } xcwf_cmd_op_e;

  typedef enum logic [1:0] {
    BeatHeader = 2'd0,
    BeatHigh   = 2'd1,
    BeatLow    = 2'd2,
    BeatCheck  = 2'd3
  } xcwf_beat_e;

  typedef struct packed {
    xcwf_cmd_op_e op;
    logic [15:0]  word;
    logic [7:0]   sync;
  } xcwf_cmd_t;

  typedef struct packed {
    logic      valid;
    xcwf_cmd_t cmd;
  } xcwf_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } xcwf_q_status_t;

endpackage

`default_nettype wire

// ----- sv/xcwf_front.sv -----
// ----------------------------------------------------------------------------
// xcwf_front
// Accepts input transactions, tracks the receive frame phase and checksum,
// and pushes deliver or send commands into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xcwf_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire xcwf_pkg::xcwf_in_item_t in_item_i,
  input  wire logic [7:0]              sync_byte_i,
  input  wire xcwf_pkg::xcwf_q_status_t q_status_i,
  output xcwf_pkg::xcwf_push_t         push_o
);

  xcwf_pkg::xcwf_phase_e phase_q, phase_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic       accept;
  logic [7:0] expect_ck;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i & ~q_status_i.full;
  assign expect_ck  = sync_byte_i ^ high_q ^ low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xcwf_pkg::PhHunt;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    high_q <= high_d;
    low_q  <= low_d;
  end

  always_comb begin
    phase_d          = phase_q;
    high_d           = high_q;
    low_d            = low_q;
    push_o.valid     = 1'b0;
    push_o.cmd.op    = xcwf_pkg::CmdSend;
    push_o.cmd.word  = in_item_i.tx_word;
    push_o.cmd.sync  = sync_byte_i;
    if (accept) begin
      if (in_item_i.kind == xcwf_pkg::KindTxWord) begin
        push_o.valid = 1'b1;
      end else begin
        case (phase_q)
          xcwf_pkg::PhHunt: begin
            if (in_item_i.rx_byte == sync_byte_i) begin
              phase_d = xcwf_pkg::PhHigh;
            end
          end
          xcwf_pkg::PhHigh: begin
            high_d  = in_item_i.rx_byte;
            phase_d = xcwf_pkg::PhLow;
          end
          xcwf_pkg::PhLow: begin
            low_d   = in_item_i.rx_byte;
            phase_d = xcwf_pkg::PhCheck;
          end
          xcwf_pkg::PhCheck: begin
            phase_d         = xcwf_pkg::PhHunt;
            push_o.cmd.op   = xcwf_pkg::CmdDeliver;
            push_o.cmd.word = {high_q, low_q};
            push_o.valid    = (in_item_i.rx_byte == expect_ck);
          end
          default: begin
            phase_d = xcwf_pkg::PhHunt;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/xcwf_queue.sv -----
// ----------------------------------------------------------------------------
// xcwf_queue
// Short command queue between front and back, first word fall-through.
// ----------------------------------------------------------------------------
`default_nettype none

module xcwf_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire xcwf_pkg::xcwf_push_t  push_i,
  input  wire logic                  pop_i,
  output xcwf_pkg::xcwf_cmd_t        head_o,
  output xcwf_pkg::xcwf_q_status_t   status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xcwf_pkg::xcwf_cmd_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(Depth));
  assign do_push        = push_i.valid & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign head_o         = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

`default_nettype wire

// ----- sv/xcwf_back.sv -----
// ----------------------------------------------------------------------------
// xcwf_back
// Drains commands: one result for a delivered word, four frame bytes for a
// send, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module xcwf_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire xcwf_pkg::xcwf_cmd_t      head_i,
  input  wire xcwf_pkg::xcwf_q_status_t q_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output xcwf_pkg::xcwf_out_item_t      out_item_o
);

  logic                     out_valid_q, out_valid_d;
  xcwf_pkg::xcwf_out_item_t out_item_q, out_item_d;
  xcwf_pkg::xcwf_beat_e     beat_q, beat_d;
  logic                     load;
  logic [7:0]               hi_byte;
  logic [7:0]               lo_byte;

  assign load        = ~out_valid_q | ~out_stall_i;
  assign hi_byte     = head_i.word[15:8];
  assign lo_byte     = head_i.word[7:0];
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    out_valid_d            = out_valid_q;
    out_item_d             = out_item_q;
    beat_d                 = beat_q;
    pop_o                  = 1'b0;
    if (load) begin
      out_valid_d = 1'b0;
      if (!q_status_i.empty) begin
        out_valid_d = 1'b1;
        if (head_i.op == xcwf_pkg::CmdDeliver) begin
          out_item_d.result_kind = xcwf_pkg::ResultRxWord;
          out_item_d.rx_word     = head_i.word;
          out_item_d.tx_byte     = 8'h00;
          out_item_d.last        = 1'b1;
          pop_o                  = 1'b1;
        end else begin
          out_item_d.result_kind = xcwf_pkg::ResultTxByte;
          out_item_d.rx_word     = 16'h0000;
          out_item_d.last        = 1'b0;
          case (beat_q)
            xcwf_pkg::BeatHeader: begin
              out_item_d.tx_byte = head_i.sync;
              beat_d             = xcwf_pkg::BeatHigh;
            end
            xcwf_pkg::BeatHigh: begin
              out_item_d.tx_byte = hi_byte;
              beat_d             = xcwf_pkg::BeatLow;
            end
            xcwf_pkg::BeatLow: begin
              out_item_d.tx_byte = lo_byte;
              beat_d             = xcwf_pkg::BeatCheck;
            end
            xcwf_pkg::BeatCheck: begin
              out_item_d.tx_byte = head_i.sync ^ hi_byte ^ lo_byte;
              out_item_d.last    = 1'b1;
              beat_d             = xcwf_pkg::BeatHeader;
              pop_o              = 1'b1;
            end
            default: begin
              beat_d = xcwf_pkg::BeatHeader;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= xcwf_pkg::BeatHeader;
    end else begin
      out_valid_q <= out_valid_d;
      beat_q      <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

endmodule

`default_nettype wire

// ----- sv/xor_checked_word_framer_top.sv -----
// ----------------------------------------------------------------------------
// xor_checked_word_framer_top
// Frames 16-bit words into four-byte XOR-checked frames and deframes
// received bytes back into words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o    xcwf_in_item_t
//  out      output     out_valid_o/out_stall_i  xcwf_out_item_t
//  cfg      input      cfg_we_i                 cfg_wdata_i (sync byte)
//
//  The front takes a received byte combinationally; the back emits a send as
//  four frame bytes, one per output beat, then pops the command.
//  Items go from the command queue into the registered output stage.
//  Reset returns to header hunting with sync byte 0xA5.
//  in_stall_o rises only when the command queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_word_framer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [7:0]               cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire xcwf_pkg::xcwf_in_item_t  in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output xcwf_pkg::xcwf_out_item_t      out_item_o
);

  logic [7:0]               sync_q;
  xcwf_pkg::xcwf_push_t     push;
  xcwf_pkg::xcwf_cmd_t      head;
  xcwf_pkg::xcwf_q_status_t q_status;
  logic                     pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= xcwf_pkg::SyncByteReset;
    end else if (cfg_we_i) begin
      sync_q <= cfg_wdata_i;
    end
  end

  xcwf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .sync_byte_i (sync_q),
    .q_status_i  (q_status),
    .push_o      (push)
  );

  xcwf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  xcwf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- bench/xor_checked_word_framer_top_tb.sv -----
// ----------------------------------------------------------------------------
// xor_checked_word_framer_top_tb
// Drives link bytes and words to send into the framer, models the header
// hunt, checksum check and frame build, and compares every output
// transaction field by field against the predicted frame bytes and words.
// Covers reset and extreme sync bytes, bad checksums, a sync change while a
// frame is open, output back-pressure, and long random framed traffic.
// ----------------------------------------------------------------------------
module xor_checked_word_framer_top_tb;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [7:0]               cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  xcwf_pkg::xcwf_in_item_t  in_item_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  xcwf_pkg::xcwf_out_item_t out_item_o;

  xor_checked_word_framer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  xcwf_pkg::xcwf_out_item_t awaited_out_q[$];
  logic [7:0]            sync_model = xcwf_pkg::SyncByteReset;
  xcwf_pkg::xcwf_phase_e rx_phase = xcwf_pkg::PhHunt;
  logic [7:0]            held_high = 8'h00;
  logic [7:0]            held_low = 8'h00;
  int                    tx_gap_max = 13;
  int                    rx_gap_max = 13;
  int                    rx_hold_cycles = 0;
  int                    errors = 0;
  int                    framed_items = 0;

  function automatic xcwf_pkg::xcwf_out_item_t make_out(logic kind, logic [15:0] word,
                                                        logic [7:0] data, logic end_flag);
    xcwf_pkg::xcwf_out_item_t r;
    r.result_kind = kind;
    r.rx_word     = word;
    r.tx_byte     = data;
    r.last        = end_flag;
    return r;
  endfunction

  task automatic predict_framer(input xcwf_pkg::xcwf_in_item_t it);
    logic [7:0] hi;
    logic [7:0] lo;
    if (it.kind == xcwf_pkg::KindTxWord) begin
      hi = it.tx_word[15:8];
      lo = it.tx_word[7:0];
      awaited_out_q.push_back(make_out(xcwf_pkg::ResultTxByte, 16'h0000, sync_model,
                                       1'b0));
      awaited_out_q.push_back(make_out(xcwf_pkg::ResultTxByte, 16'h0000, hi, 1'b0));
      awaited_out_q.push_back(make_out(xcwf_pkg::ResultTxByte, 16'h0000, lo, 1'b0));
      awaited_out_q.push_back(make_out(xcwf_pkg::ResultTxByte, 16'h0000,
                                       sync_model ^ hi ^ lo, 1'b1));
    end else begin
      case (rx_phase)
        xcwf_pkg::PhHunt: begin
          if (it.rx_byte == sync_model) rx_phase = xcwf_pkg::PhHigh;
        end
        xcwf_pkg::PhHigh: begin
          held_high = it.rx_byte;
          rx_phase  = xcwf_pkg::PhLow;
        end
        xcwf_pkg::PhLow: begin
          held_low = it.rx_byte;
          rx_phase = xcwf_pkg::PhCheck;
        end
        default: begin
          rx_phase = xcwf_pkg::PhHunt;
          if (it.rx_byte == (sync_model ^ held_high ^ held_low))
            awaited_out_q.push_back(make_out(xcwf_pkg::ResultRxWord,
                                             {held_high, held_low}, 8'h00, 1'b1));
        end
      endcase
    end
  endtask

  task automatic send_item(input xcwf_pkg::xcwf_in_item_t it);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_framer(it);
    @(negedge clk_i);
  endtask

  task automatic send_rx(input logic [7:0] data);
    xcwf_pkg::xcwf_in_item_t it;
    it.kind    = xcwf_pkg::KindRxByte;
    it.rx_byte = data;
    it.tx_word = 16'($urandom_range(0, 16'hFFFF));
    send_item(it);
  endtask

  task automatic send_tx(input logic [15:0] word);
    xcwf_pkg::xcwf_in_item_t it;
    it.kind    = xcwf_pkg::KindTxWord;
    it.rx_byte = 8'($urandom_range(0, 8'hFF));
    it.tx_word = word;
    send_item(it);
    framed_items++;
  endtask

  // corrupt is XORed into the checksum byte; zero sends a good frame
  task automatic send_frame(input logic [15:0] word, input logic [7:0] corrupt);
    send_rx(sync_model);
    send_rx(word[15:8]);
    send_rx(word[7:0]);
    send_rx(sync_model ^ word[15:8] ^ word[7:0] ^ corrupt);
    framed_items += 4;
  endtask

  task automatic drain_results();
    int n;
    in_valid_i = 1'b0;
    for (n = 0; n < 20000 && awaited_out_q.size() != 0; n++) @(posedge clk_i);
    if (awaited_out_q.size() != 0) begin
      $display("%0t: missing results: expected %0d more, actual none", $time,
               awaited_out_q.size());
      errors++;
      awaited_out_q.delete();
    end
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] value);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sync_model = value;
  endtask

  task automatic test_reset_sync();
    send_frame(16'h0000, 8'h00);
    send_frame(16'hFFFF, 8'h00);
    send_tx(16'h0000);
    send_tx(16'hFFFF);
    // bad checksum equal to the header must not restart a frame
    send_rx(sync_model);
    send_rx(8'h12);
    send_rx(8'h34);
    send_rx(sync_model);
    send_rx(8'h12);
    send_frame({sync_model, sync_model}, 8'h00);
    // send while a frame is half received
    send_rx(sync_model);
    send_rx(8'h5A);
    send_tx(16'h1234);
    send_rx(8'hC3);
    send_rx(sync_model ^ 8'h5A ^ 8'hC3);
    // change the sync byte before the checksum arrives
    send_rx(sync_model);
    send_rx(8'h01);
    send_rx(8'h02);
    write_sync(8'h3C);
    send_rx(8'h3C ^ 8'h01 ^ 8'h02);
  endtask

  task automatic test_sync_extremes();
    write_sync(8'h00);
    send_frame(16'h0000, 8'h00);
    send_frame(16'hFF00, 8'h00);
    send_frame(16'h00FF, 8'h80);
    send_tx(16'hFFFF);
    write_sync(8'hFF);
    send_frame(16'hFFFF, 8'h00);
    send_frame(16'h00FF, 8'h00);
    send_frame(16'h1234, 8'h01);
    send_tx(16'h0000);
  endtask

  task automatic test_output_hold_off();
    drain_results();
    tx_gap_max     = 0;
    rx_gap_max     = 0;
    rx_hold_cycles = 300;
    repeat (10) send_tx(16'($urandom_range(0, 16'hFFFF)));
    send_frame(16'($urandom_range(0, 16'hFFFF)), 8'h00);
    repeat (4) send_tx(16'($urandom_range(0, 16'hFFFF)));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int seg;
    int pick;
    int start_items;
    int gap_choice[3] = '{0, 3, 13};
    for (seg = 0; seg < 6; seg++) begin
      if (seg == 0) write_sync(8'h00);
      else if (seg == 1) write_sync(8'hFF);
      else write_sync(8'($urandom_range(0, 8'hFF)));
      tx_gap_max  = gap_choice[2'($urandom_range(0, 2))];
      rx_gap_max  = gap_choice[2'($urandom_range(0, 2))];
      start_items = framed_items;
      while (framed_items - start_items < 62) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_frame(16'($urandom_range(0, 16'hFFFF)), 8'h00);
        end else if (pick < 65) begin
          send_tx(16'($urandom_range(0, 16'hFFFF)));
        end else if (pick < 75) begin
          send_frame(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(1, 8'hFF)));
        end else if (pick < 80) begin
          send_rx(sync_model);
          send_rx(8'($urandom_range(0, 8'hFF)));
          framed_items += 2;
        end else if (pick < 95) begin
          send_rx(8'($urandom_range(0, 8'hFF)));
          framed_items++;
        end else begin
          send_rx(sync_model);
          framed_items++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    xcwf_pkg::xcwf_out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_out_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time,
                 out_item_o);
        errors++;
      end else begin
        want = awaited_out_q.pop_front();
        check_field("result_kind", 16'(want.result_kind), 16'(out_item_o.result_kind));
        check_field("rx_word", want.rx_word, out_item_o.rx_word);
        check_field("tx_byte", 16'(want.tx_byte), 16'(out_item_o.tx_byte));
        check_field("last", 16'(want.last), 16'(out_item_o.last));
      end
    end
  end

  initial begin : drive_out_stall
    int n;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        n              = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_stall_i    = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      n = $urandom_range(0, rx_gap_max);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'h00;
    rst_ni      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_sync();
    test_sync_extremes();
    test_output_hold_off();
    test_random_traffic();
    drain_results();
    if (errors == 0) begin
      $display("xor_checked_word_framer_top test passed");
    end else begin
      $display("xor_checked_word_framer_top test failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("xor_checked_word_framer_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/xcwf_pkg.sv
sv/xcwf_front.sv
sv/xcwf_queue.sv
sv/xcwf_back.sv
sv/xor_checked_word_framer_top.sv
bench/xor_checked_word_framer_top_tb.sv
